### rtl/matrix_inverse_mod26_macros.svh
// Assertion macros shared by the matrix inverse mod 26 block.
// Depends on nothing; taken in by the files that carry assertions.
`ifndef MATRIX_INVERSE_MOD26_MACROS_SVH
`define MATRIX_INVERSE_MOD26_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MIM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mim26_pkg.sv
// Shared types, constants and residue helpers for the matrix inverse mod 26 block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mim26_pkg;

  localparam int unsigned ElemW   = 5;
  localparam int unsigned NumElem = 9;
  localparam int unsigned Modulus = 26;

  // Key matrix order codes; only the two square orders are valid.
  localparam logic [1:0] OrderNone = 2'd0;
  localparam logic [1:0] OrderOne  = 2'd1;
  localparam logic [1:0] Order2x2  = 2'd2;
  localparam logic [1:0] Order3x3  = 2'd3;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [NumElem-1:0][ElemW-1:0] mat_t;

  // Stage enables handed from the valid chain to the lanes and merge unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_en_t;

  // Reduce a value below 2048 modulo 26 by a reciprocal multiply.
  // The quotient estimate is low by at most one, so one correction suffices.
  function automatic elem_t mod26(input logic [10:0] x);
    logic [19:0] scaled;
    logic [6:0]  quo;
    logic [10:0] quo_m;
    logic [10:0] rem;
    logic [10:0] rem_c;
    scaled = {9'd0, x} * 20'd315;
    quo    = scaled[19:13];
    quo_m  = {4'd0, quo} * 11'(Modulus);
    rem    = x - quo_m;
    rem_c  = rem - 11'(Modulus);
    if (rem >= 11'(Modulus)) begin
      return rem_c[ElemW-1:0];
    end
    return rem[ElemW-1:0];
  endfunction

  // Bring a raw 5-bit entry into 0..25.
  function automatic elem_t reduce_entry(input elem_t v);
    elem_t v_c;
    v_c = v - ElemW'(Modulus);
    if (v >= ElemW'(Modulus)) begin
      return v_c;
    end
    return v;
  endfunction

  // Inverse of a residue mod 26; zero marks a residue without one.
  function automatic elem_t unit_inverse(input elem_t d);
    case (d)
      5'd1:    return 5'd1;
      5'd3:    return 5'd9;
      5'd5:    return 5'd21;
      5'd7:    return 5'd15;
      5'd9:    return 5'd3;
      5'd11:   return 5'd19;
      5'd15:   return 5'd7;
      5'd17:   return 5'd23;
      5'd19:   return 5'd11;
      5'd21:   return 5'd5;
      5'd23:   return 5'd17;
      5'd25:   return 5'd25;
      default: return 5'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/mim26_lane.sv
// One adjugate lane: computes (p*q - r*s) mod 26 over two register stages.
// Depends on mim26_pkg for the element type, stage enables and mod26 helper.
`default_nettype none

module mim26_lane (
  input  wire logic              clk,
  input  wire mim26_pkg::pipe_en_t en,
  input  wire mim26_pkg::elem_t  p,
  input  wire mim26_pkg::elem_t  q,
  input  wire mim26_pkg::elem_t  r,
  input  wire mim26_pkg::elem_t  s,
  output mim26_pkg::elem_t       adj
);

  logic [9:0]  pq;
  logic [9:0]  rs;
  logic [10:0] diff_nxt;
  logic [10:0] diff_r;
  mim26_pkg::elem_t adj_r;

  // The offset of 650, a multiple of 26, keeps the difference positive for entries in 0..25.
  assign pq       = {5'd0, p} * {5'd0, q};
  assign rs       = {5'd0, r} * {5'd0, s};
  assign diff_nxt = {1'b0, pq} + 11'd650 - {1'b0, rs};

  // First stage holds the raw difference, second its residue.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      diff_r <= diff_nxt;
    end
    if (en.s2) begin
      adj_r <= mim26_pkg::mod26(diff_r);
    end
  end

  assign adj = adj_r;

endmodule

`default_nettype wire

### rtl/mim26_merge.sv
// Merge unit: forms the determinant from the lane results, looks up its inverse
// and scales every adjugate entry. Depends on mim26_pkg.
`default_nettype none

module mim26_merge (
  input  wire logic               clk,
  input  wire mim26_pkg::pipe_en_t en,
  input  wire logic               ok,
  input  wire mim26_pkg::elem_t   m00,
  input  wire mim26_pkg::elem_t   m01,
  input  wire mim26_pkg::elem_t   m02,
  input  wire mim26_pkg::mat_t    adj,
  output logic                    invertible,
  output mim26_pkg::mat_t         b
);

  localparam int unsigned N = mim26_pkg::NumElem;

  logic [10:0]       dsum_r;
  mim26_pkg::mat_t   adj3_r;
  logic              ok3_r;
  mim26_pkg::elem_t  dinv_nxt;
  mim26_pkg::elem_t  dinv_r;
  mim26_pkg::mat_t   adj4_r;
  logic [N-1:0][9:0] prod_r;
  logic              inv5_r;
  mim26_pkg::mat_t   b_r;
  logic              inv6_r;
  logic [9:0]        t0;
  logic [9:0]        t1;
  logic [9:0]        t2;

  // Expansion along row 0; for order two the third term is zero.
  assign t0 = {5'd0, m00} * {5'd0, adj[0]};
  assign t1 = {5'd0, m01} * {5'd0, adj[3]};
  assign t2 = {5'd0, m02} * {5'd0, adj[6]};

  // A bad order forces the inverse to zero, which zeroes every entry.
  assign dinv_nxt = ok3_r ? mim26_pkg::unit_inverse(mim26_pkg::mod26(dsum_r)) : '0;

  always_ff @(posedge clk) begin
    // Determinant sum.
    if (en.s3) begin
      dsum_r <= {1'b0, t0} + {1'b0, t1} + {1'b0, t2};
      adj3_r <= adj;
      ok3_r  <= ok;
    end
    // Determinant residue and its inverse.
    if (en.s4) begin
      dinv_r <= dinv_nxt;
      adj4_r <= adj3_r;
    end
    // Scale each entry by the inverse.
    if (en.s5) begin
      for (int k = 0; k < N; k++) begin
        prod_r[k] <= {5'd0, adj4_r[k]} * {5'd0, dinv_r};
      end
      inv5_r <= (dinv_r != '0);
    end
    // Output register.
    if (en.s6) begin
      for (int k = 0; k < N; k++) begin
        b_r[k] <= mim26_pkg::mod26({1'b0, prod_r[k]});
      end
      inv6_r <= inv5_r;
    end
  end

  assign invertible = inv6_r;
  assign b          = b_r;

endmodule

`default_nettype wire

### rtl/matrix_inverse_mod26.sv
// Top level of the matrix inverse mod 26 block: input stage, lane operand
// selection, stage valid chain and output ports. Depends on mim26_pkg,
// mim26_lane, mim26_merge and matrix_inverse_mod26_macros.svh.
//
//   Channel  Ports                               Direction  Moves
//   in       in_valid, in_stall, in_matrix_order, in_a00..in_a22   in   one key matrix
//   out      out_valid, out_stall, out_invertible, out_b00..out_b22  out  its inverse
//
// One matrix is taken per cycle while in_stall is low; a result passes the input register,
// two lane stages and four merge stages, in that order.
// Reset clears only the stage valid bits; the data registers are left as they are.
// A stall on the output holds each full stage; empty stages still fill, so bubbles
// close up before the input is stalled.
`default_nettype none
`include "matrix_inverse_mod26_macros.svh"

module matrix_inverse_mod26 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_matrix_order,
  input  wire logic [4:0] in_a00,
  input  wire logic [4:0] in_a01,
  input  wire logic [4:0] in_a02,
  input  wire logic [4:0] in_a10,
  input  wire logic [4:0] in_a11,
  input  wire logic [4:0] in_a12,
  input  wire logic [4:0] in_a20,
  input  wire logic [4:0] in_a21,
  input  wire logic [4:0] in_a22,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_invertible,
  output logic [4:0]      out_b00,
  output logic [4:0]      out_b01,
  output logic [4:0]      out_b02,
  output logic [4:0]      out_b10,
  output logic [4:0]      out_b11,
  output logic [4:0]      out_b12,
  output logic [4:0]      out_b20,
  output logic [4:0]      out_b21,
  output logic [4:0]      out_b22
);

  localparam int unsigned N      = mim26_pkg::NumElem;
  localparam int unsigned NStage = 7;

  logic [NStage-1:0] vld_r;
  logic [NStage-1:0] vld_nxt;
  logic [NStage:0]   rdy;
  mim26_pkg::pipe_en_t en;

  mim26_pkg::mat_t  raw;
  mim26_pkg::mat_t  m_r;
  logic             ok0_r;
  logic             ord3_r;
  logic [2:0][4:0]  row1_r;
  logic [2:0][4:0]  row2_r;
  logic             ok1_r;
  logic             ok2_r;

  mim26_pkg::mat_t  lp;
  mim26_pkg::mat_t  lq;
  mim26_pkg::mat_t  lr;
  mim26_pkg::mat_t  ls;
  mim26_pkg::mat_t  adj;
  mim26_pkg::mat_t  b;

  // Ready runs back from the output: a stage moves when empty or when the next moves.
  always_comb begin
    rdy[NStage] = !out_stall;
    for (int k = NStage - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];
  assign en.s1    = rdy[1];
  assign en.s2    = rdy[2];
  assign en.s3    = rdy[3];
  assign en.s4    = rdy[4];
  assign en.s5    = rdy[5];
  assign en.s6    = rdy[6];

  // Valid chain.
  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NStage; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign raw = {in_a22, in_a21, in_a20, in_a12, in_a11, in_a10, in_a02, in_a01, in_a00};

  // Input register: entries reduced into 0..25 on the transfer.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int k = 0; k < N; k++) begin
        m_r[k] <= mim26_pkg::reduce_entry(raw[k]);
      end
      ok0_r  <= (in_matrix_order inside {mim26_pkg::Order2x2, mim26_pkg::Order3x3});
      ord3_r <= (in_matrix_order == mim26_pkg::Order3x3);
    end
    if (rdy[1]) begin
      row1_r <= {m_r[2], m_r[1], m_r[0]};
      ok1_r  <= ok0_r;
    end
    if (rdy[2]) begin
      row2_r <= row1_r;
      ok2_r  <= ok1_r;
    end
  end

  // Lane operands: entry k = i*3+j of the adjugate is p*q - r*s.
  // Order three uses the transposed cofactors, order two swap and negate.
  always_comb begin
    lp = '0;
    lq = '0;
    lr = '0;
    ls = '0;
    if (ord3_r) begin
      lp[0] = m_r[4]; lq[0] = m_r[8]; lr[0] = m_r[5]; ls[0] = m_r[7];
      lp[1] = m_r[2]; lq[1] = m_r[7]; lr[1] = m_r[1]; ls[1] = m_r[8];
      lp[2] = m_r[1]; lq[2] = m_r[5]; lr[2] = m_r[2]; ls[2] = m_r[4];
      lp[3] = m_r[5]; lq[3] = m_r[6]; lr[3] = m_r[3]; ls[3] = m_r[8];
      lp[4] = m_r[0]; lq[4] = m_r[8]; lr[4] = m_r[2]; ls[4] = m_r[6];
      lp[5] = m_r[2]; lq[5] = m_r[3]; lr[5] = m_r[0]; ls[5] = m_r[5];
      lp[6] = m_r[3]; lq[6] = m_r[7]; lr[6] = m_r[4]; ls[6] = m_r[6];
      lp[7] = m_r[1]; lq[7] = m_r[6]; lr[7] = m_r[0]; ls[7] = m_r[7];
      lp[8] = m_r[0]; lq[8] = m_r[4]; lr[8] = m_r[1]; ls[8] = m_r[3];
    end else begin
      lp[0] = m_r[4]; lq[0] = 5'd1;
      lr[1] = m_r[1]; ls[1] = 5'd1;
      lr[3] = m_r[3]; ls[3] = 5'd1;
      lp[4] = m_r[0]; lq[4] = 5'd1;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_lane
    mim26_lane u_lane (
      .clk (clk),
      .en  (en),
      .p   (lp[g]),
      .q   (lq[g]),
      .r   (lr[g]),
      .s   (ls[g]),
      .adj (adj[g])
    );
  end

  mim26_merge u_merge (
    .clk        (clk),
    .en         (en),
    .ok         (ok2_r),
    .m00        (row2_r[0]),
    .m01        (row2_r[1]),
    .m02        (row2_r[2]),
    .adj        (adj),
    .invertible (out_invertible),
    .b          (b)
  );

  assign out_valid = vld_r[NStage-1];
  assign out_b00   = b[0];
  assign out_b01   = b[1];
  assign out_b02   = b[2];
  assign out_b10   = b[3];
  assign out_b11   = b[4];
  assign out_b12   = b[5];
  assign out_b20   = b[6];
  assign out_b21   = b[7];
  assign out_b22   = b[8];

  // Checks on the stage chain and the singular result.
  `MIM_ASSERT_SAME(a_stall_needs_full, clk, rst_n, in_stall, vld_r[0], "stall with stage empty")
  `MIM_ASSERT_SAME(a_free_out_no_stall, clk, rst_n, !out_stall, !in_stall, "stall, output free")
  `MIM_ASSERT_NEXT(a_transfer_lands, clk, rst_n, in_valid && !in_stall, vld_r[0], "transfer lost")
  `MIM_ASSERT_SAME(a_singular_zero, clk, rst_n, out_valid && !out_invertible, b == '0, "nonzero b")

endmodule

`default_nettype wire

### verif/matrix_inverse_mod26_tb.sv
// Testbench for matrix_inverse_mod26: drives key matrices, predicts each inverse mod 26
// and checks every result transfer in order. Depends on mim26_pkg and the block's RTL.
`timescale 1ns / 1ps

module matrix_inverse_mod26_tb;

  localparam int         KeyMod     = 26;
  localparam int         HoldCycles = 64;
  localparam int         CycleLimit = 200000;

  // One expected inverse: flag plus nine entries, entry k at row k/3, column k%3.
  typedef struct packed {
    logic            invertible;
    mim26_pkg::mat_t b;
  } key_inverse_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_matrix_order = '0;
  logic [4:0] in_a00 = '0, in_a01 = '0, in_a02 = '0;
  logic [4:0] in_a10 = '0, in_a11 = '0, in_a12 = '0;
  logic [4:0] in_a20 = '0, in_a21 = '0, in_a22 = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_invertible;
  logic [4:0] out_b00, out_b01, out_b02;
  logic [4:0] out_b10, out_b11, out_b12;
  logic [4:0] out_b20, out_b21, out_b22;

  key_inverse_t inverse_q [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           gaps_on = 1'b1;
  int           burst_left = 0;
  logic         hold_go = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_left = 0;
  int           stall_pct = 0;
  int           phase_left = 0;

  matrix_inverse_mod26 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_matrix_order (in_matrix_order),
    .in_a00          (in_a00),
    .in_a01          (in_a01),
    .in_a02          (in_a02),
    .in_a10          (in_a10),
    .in_a11          (in_a11),
    .in_a12          (in_a12),
    .in_a20          (in_a20),
    .in_a21          (in_a21),
    .in_a22          (in_a22),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_invertible  (out_invertible),
    .out_b00         (out_b00),
    .out_b01         (out_b01),
    .out_b02         (out_b02),
    .out_b10         (out_b10),
    .out_b11         (out_b11),
    .out_b12         (out_b12),
    .out_b20         (out_b20),
    .out_b21         (out_b21),
    .out_b22         (out_b22)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reduce a signed value into 0..25.
  function automatic int residue(input int x);
    return ((x % KeyMod) + KeyMod) % KeyMod;
  endfunction

  // Inverse of one key matrix mod 26, built from the adjugate and the determinant's inverse.
  function automatic key_inverse_t invert_key(input logic [1:0] order,
                                              input mim26_pkg::mat_t raw);
    key_inverse_t res;
    int m [3][3];
    int cof [3][3];
    int adj [3][3];
    int det;
    int det_inv;
    int i, j, r0, r1, c0, c1, minor;
    det = 0;
    det_inv = 0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        m[i][j] = int'(raw[i*3+j]) % KeyMod;
        adj[i][j] = 0;
      end
    end
    if (order == mim26_pkg::Order2x2) begin
      det = residue(m[0][0] * m[1][1] - m[0][1] * m[1][0]);
      adj[0][0] = m[1][1];
      adj[0][1] = residue(-m[0][1]);
      adj[1][0] = residue(-m[1][0]);
      adj[1][1] = m[0][0];
    end else if (order == mim26_pkg::Order3x3) begin
      // Signed cofactors from the 2x2 minors, then the transpose.
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          r0 = (i == 0) ? 1 : 0;
          r1 = (i == 2) ? 1 : 2;
          c0 = (j == 0) ? 1 : 0;
          c1 = (j == 2) ? 1 : 2;
          minor = m[r0][c0] * m[r1][c1] - m[r0][c1] * m[r1][c0];
          cof[i][j] = residue(((i + j) % 2 == 0) ? minor : -minor);
        end
      end
      det = residue(m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2]);
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          adj[i][j] = cof[j][i];
        end
      end
    end
    // Search for the multiplicative inverse; none exists for even or 13-multiple values.
    for (i = 1; i < KeyMod; i++) begin
      if ((det * i) % KeyMod == 1) begin
        det_inv = i;
      end
    end
    res.invertible = (det_inv != 0);
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        res.b[i*3+j] = mim26_pkg::elem_t'((adj[i][j] * det_inv) % KeyMod);
      end
    end
    return res;
  endfunction

  // Offer one matrix, with an idle gap before each burst when gaps are on, and wait for its transfer.
  task automatic send_matrix(input logic [1:0] order, input mim26_pkg::mat_t raw);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid        <= 1'b1;
    in_matrix_order <= order;
    in_a00 <= raw[0];
    in_a01 <= raw[1];
    in_a02 <= raw[2];
    in_a10 <= raw[3];
    in_a11 <= raw[4];
    in_a12 <= raw[5];
    in_a20 <= raw[6];
    in_a21 <= raw[7];
    in_a22 <= raw[8];
    do @(posedge clk); while (in_stall);
    inverse_q.push_back(invert_key(order, raw));
  endtask

  task automatic send_key(input logic [1:0] order,
                          input int a00, input int a01, input int a02,
                          input int a10, input int a11, input int a12,
                          input int a20, input int a21, input int a22);
    mim26_pkg::mat_t raw;
    raw = {5'(a22), 5'(a21), 5'(a20), 5'(a12), 5'(a11), 5'(a10), 5'(a02), 5'(a01), 5'(a00)};
    send_matrix(order, raw);
  endtask

  // Mostly well-formed keys of either order; a few bad orders and entries above 25.
  task automatic send_random_key();
    mim26_pkg::mat_t raw;
    logic [1:0]      order;
    int              pick;
    int              k;
    pick = $urandom_range(99);
    if (pick < 45) begin
      order = mim26_pkg::Order2x2;
    end else if (pick < 90) begin
      order = mim26_pkg::Order3x3;
    end else begin
      order = ($urandom_range(1) == 0) ? mim26_pkg::OrderNone : mim26_pkg::OrderOne;
    end
    for (k = 0; k < mim26_pkg::NumElem; k++) begin
      raw[k] = ($urandom_range(99) < 85) ? mim26_pkg::elem_t'($urandom_range(25))
                                         : mim26_pkg::elem_t'($urandom_range(31));
    end
    send_matrix(order, raw);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
  endtask

  // Extremes, each order, singular determinants, bad orders and entries above 25.
  task automatic test_directed_cases();
    gaps_on = 1'b0;
    send_key(mim26_pkg::Order3x3, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_key(mim26_pkg::Order2x2, 1, 0, 0, 0, 1, 0, 0, 0, 0);
    send_key(mim26_pkg::Order2x2, 3, 3, 7, 2, 5, 9, 31, 31, 31);
    send_key(mim26_pkg::Order3x3, 6, 24, 1, 13, 16, 10, 20, 17, 15);
    send_key(mim26_pkg::Order2x2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_key(mim26_pkg::Order3x3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_key(mim26_pkg::Order3x3, 25, 25, 25, 25, 25, 25, 25, 25, 25);
    send_key(mim26_pkg::Order2x2, 25, 25, 0, 25, 25, 0, 0, 0, 0);
    send_key(mim26_pkg::Order2x2, 25, 0, 0, 0, 1, 0, 0, 0, 0);
    send_key(mim26_pkg::Order3x3, 25, 0, 0, 0, 1, 0, 0, 0, 1);
    send_key(mim26_pkg::Order2x2, 13, 0, 0, 0, 1, 0, 0, 0, 0);
    send_key(mim26_pkg::Order2x2, 2, 0, 0, 0, 1, 0, 0, 0, 0);
    send_key(mim26_pkg::Order3x3, 27, 26, 26, 26, 27, 26, 26, 26, 27);
    send_key(mim26_pkg::Order3x3, 31, 31, 31, 31, 31, 31, 31, 31, 31);
    send_key(mim26_pkg::Order2x2, 31, 26, 0, 26, 31, 0, 0, 0, 0);
    send_key(mim26_pkg::Order2x2, 31, 30, 0, 29, 28, 0, 0, 0, 0);
    send_key(mim26_pkg::Order3x3, 25, 24, 23, 22, 21, 20, 19, 18, 17);
    send_key(mim26_pkg::Order3x3, 2, 5, 7, 11, 3, 8, 1, 9, 4);
    send_key(mim26_pkg::OrderNone, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_key(mim26_pkg::OrderOne, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while matrices keep coming back to back.
  task automatic test_backpressure();
    int n;
    gaps_on = 1'b0;
    hold_go <= ~hold_go;
    for (n = 0; n < 40; n++) begin
      send_random_key();
    end
    wait_for_results();
  endtask

  // Short bursts, each followed by a pause until every result is back.
  task automatic test_drain_pause();
    int round, n;
    gaps_on = 1'b1;
    for (round = 0; round < 3; round++) begin
      for (n = 0; n < 5; n++) begin
        send_random_key();
      end
      wait_for_results();
    end
  endtask

  // Bulk random traffic; sender gaps are switched off for one chunk.
  task automatic test_random_traffic();
    int chunk, n;
    for (chunk = 0; chunk < 3; chunk++) begin
      gaps_on = (chunk != 2);
      for (n = 0; n < 100; n++) begin
        send_random_key();
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver stall pattern: random phases of varying stall density, plus the long hold.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(4))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 25;
          3:       stall_pct <= 50;
          default: stall_pct <= 75;
        endcase
        phase_left <= $urandom_range(20, 80);
      end else begin
        phase_left <= phase_left - 1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every result transfer with the oldest outstanding inverse.
  always @(posedge clk) begin : check_results
    key_inverse_t    want;
    mim26_pkg::mat_t got;
    int              k;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_b22, out_b21, out_b20, out_b12, out_b11, out_b10, out_b02, out_b01, out_b00};
      if (inverse_q.size() == 0) begin
        $error("result transfer with no matrix outstanding");
        mismatch_count++;
      end else begin
        want = inverse_q.pop_front();
        if (out_invertible !== want.invertible) begin
          $error("invertible mismatch: expected %0d, got %0d", want.invertible, out_invertible);
          mismatch_count++;
        end
        for (k = 0; k < mim26_pkg::NumElem; k++) begin
          if (got[k] !== want.b[k]) begin
            $error("b%0d%0d mismatch: expected %0d, got %0d", k / 3, k % 3, want.b[k], got[k]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mim26_pkg.sv
rtl/mim26_lane.sv
rtl/mim26_merge.sv
rtl/matrix_inverse_mod26.sv
verif/matrix_inverse_mod26_tb.sv
